[rtl/core/kbd_pkg.sv]
// Shared types, constants and scancode tables for the keyboard line editor.
`default_nettype none

package kbd_pkg;

    localparam int INPUT_BUFFER_LEN = 64;
    localparam int LINE_CAP         = INPUT_BUFFER_LEN - 2;
    localparam int ADDR_W           = $clog2(LINE_CAP);
    localparam int LEN_W            = $clog2(LINE_CAP + 1);
    localparam int QDEPTH           = 4;
    localparam int QAW              = $clog2(QDEPTH);

    typedef logic [7:0]        t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_len LEN_ONE = t_len'(1);
    localparam t_len LEN_CAP = t_len'(LINE_CAP);

    localparam t_byte KEY_PREFIX  = 8'hE0;
    localparam t_byte KEY_RELEASE = 8'h80;
    localparam t_byte KEY_LSHIFT  = 8'h2A;
    localparam t_byte KEY_RSHIFT  = 8'h36;
    localparam t_byte KEY_CTRL    = 8'h1D;
    localparam t_byte KEY_CAPS    = 8'h3A;
    localparam t_byte NAV_LEFT    = 8'h4B;
    localparam t_byte NAV_RIGHT   = 8'h4D;
    localparam t_byte NAV_HOME    = 8'h47;
    localparam t_byte NAV_END     = 8'h4F;
    localparam t_byte NAV_DEL     = 8'h53;
    localparam t_byte CODE_LIMIT  = 8'h40;

    localparam t_byte CH_BS       = 8'h08;
    localparam t_byte CH_TAB      = 8'h09;
    localparam t_byte CH_LF       = 8'h0A;
    localparam t_byte CH_CR       = 8'h0D;
    localparam t_byte CH_SPACE    = 8'h20;
    localparam t_byte CH_DEL      = 8'h7F;
    localparam t_byte CH_LC_A     = 8'h61;
    localparam t_byte CH_LC_Z     = 8'h7A;
    localparam t_byte CASE_BIT    = 8'h20;
    localparam t_byte CTRL_MASK   = 8'h1F;

    typedef enum logic [2:0] {
        OP_INS,
        OP_BS,
        OP_DEL,
        OP_LEFT,
        OP_RIGHT,
        OP_HOME,
        OP_END,
        OP_ENTER
    } t_op;

    typedef struct packed {
        t_op   op;
        t_byte ch;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_FIN,
        S_REM,
        S_OUT,
        S_NL
    } t_state;

    function automatic t_byte plain_map(input logic [5:0] idx);
        t_byte v;
        unique case (idx)
            6'h01: v = 8'h1B;
            6'h02: v = 8'h31;
            6'h03: v = 8'h32;
            6'h04: v = 8'h33;
            6'h05: v = 8'h34;
            6'h06: v = 8'h35;
            6'h07: v = 8'h36;
            6'h08: v = 8'h37;
            6'h09: v = 8'h38;
            6'h0A: v = 8'h39;
            6'h0B: v = 8'h30;
            6'h0C: v = 8'h2D;
            6'h0D: v = 8'h3D;
            6'h0E: v = 8'h08;
            6'h0F: v = 8'h09;
            6'h10: v = 8'h71;
            6'h11: v = 8'h77;
            6'h12: v = 8'h65;
            6'h13: v = 8'h72;
            6'h14: v = 8'h74;
            6'h15: v = 8'h79;
            6'h16: v = 8'h75;
            6'h17: v = 8'h69;
            6'h18: v = 8'h6F;
            6'h19: v = 8'h70;
            6'h1A: v = 8'h5B;
            6'h1B: v = 8'h5D;
            6'h1C: v = 8'h0A;
            6'h1E: v = 8'h61;
            6'h1F: v = 8'h73;
            6'h20: v = 8'h64;
            6'h21: v = 8'h66;
            6'h22: v = 8'h67;
            6'h23: v = 8'h68;
            6'h24: v = 8'h6A;
            6'h25: v = 8'h6B;
            6'h26: v = 8'h6C;
            6'h27: v = 8'h3B;
            6'h28: v = 8'h27;
            6'h29: v = 8'h60;
            6'h2B: v = 8'h5C;
            6'h2C: v = 8'h7A;
            6'h2D: v = 8'h78;
            6'h2E: v = 8'h63;
            6'h2F: v = 8'h76;
            6'h30: v = 8'h62;
            6'h31: v = 8'h6E;
            6'h32: v = 8'h6D;
            6'h33: v = 8'h2C;
            6'h34: v = 8'h2E;
            6'h35: v = 8'h2F;
            6'h37: v = 8'h2A;
            6'h39: v = 8'h20;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_byte shift_map(input logic [5:0] idx);
        t_byte v;
        unique case (idx)
            6'h02: v = 8'h21;
            6'h03: v = 8'h40;
            6'h04: v = 8'h23;
            6'h05: v = 8'h24;
            6'h06: v = 8'h25;
            6'h07: v = 8'h5E;
            6'h08: v = 8'h26;
            6'h09: v = 8'h2A;
            6'h0A: v = 8'h28;
            6'h0B: v = 8'h29;
            6'h0C: v = 8'h5F;
            6'h0D: v = 8'h2B;
            6'h1A: v = 8'h7B;
            6'h1B: v = 8'h7D;
            6'h27: v = 8'h3A;
            6'h28: v = 8'h22;
            6'h29: v = 8'h7E;
            6'h2B: v = 8'h7C;
            6'h33: v = 8'h3C;
            6'h34: v = 8'h3E;
            6'h35: v = 8'h3F;
            6'h37: v = 8'h2A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ps2_keyboard_line_editor.sv]
// Top level: PS/2 set-1 keyboard decoder with line editing and line commit stream.
// Input beats are taken one per cycle while the 4-entry command queue has room.
// Back end: moves and appends finish in idle, mid-line insert shifts the tail up then writes
// the char, inner delete/backspace shift the tail down, commit streams the line then LF.
// A commit streams one beat per cycle from the line RAM read port when the sink is ready.
// Synchronous active-low reset clears modifiers, queue, length, cursor and output valid.
`default_nettype none

module ps2_keyboard_line_editor import kbd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,  // [7:0] scan_code
    input  wire logic [0:0] i_s_axis_tuser,  // [0] from_aux
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic      [7:0] o_m_axis_tdata,  // [7:0] char_out
    output logic            o_m_axis_tlast   // line_end
);

    logic fifo_full;
    logic fe_push;
    t_cmd fe_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    kbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_scan_code (i_s_axis_tdata),
        .i_from_aux  (i_s_axis_tuser[0]),
        .i_full      (fifo_full),
        .o_ready     (o_s_axis_tready),
        .o_push      (fe_push),
        .o_cmd       (fe_cmd)
    );

    kbd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_cmd   (fe_cmd),
        .o_full  (fifo_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    kbd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_cmd_pop       (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

[rtl/core/kbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/kbd_front.sv]
// Front end: takes scancode beats, tracks modifiers and prefix, emits edit commands.
`default_nettype none

module kbd_front import kbd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_byte i_scan_code,
    input  wire logic  i_from_aux,
    input  wire logic  i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic r_shift, n_shift;
    logic r_ctrl, n_ctrl;
    logic r_caps, n_caps;
    logic r_prefix, n_prefix;

    logic  accept;
    logic  nav_valid;
    t_op   nav_op;
    logic  chr_valid;
    t_op   chr_op;
    t_byte chr;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        nav_valid = 1'b1;
        nav_op    = OP_LEFT;
        if (i_scan_code == NAV_LEFT) begin
            nav_op = OP_LEFT;
        end else if (i_scan_code == NAV_RIGHT) begin
            nav_op = OP_RIGHT;
        end else if (i_scan_code == NAV_HOME) begin
            nav_op = OP_HOME;
        end else if (i_scan_code == NAV_END) begin
            nav_op = OP_END;
        end else if (i_scan_code == NAV_DEL) begin
            nav_op = OP_DEL;
        end else begin
            nav_valid = 1'b0;
        end
    end

    always_comb begin
        t_byte base;
        t_byte sym;
        base = plain_map(i_scan_code[5:0]);
        sym  = shift_map(i_scan_code[5:0]);
        if (base >= CH_LC_A && base <= CH_LC_Z) begin
            if (r_ctrl) begin
                chr = base & CTRL_MASK;
            end else if (r_shift ^ r_caps) begin
                chr = base - CASE_BIT;
            end else begin
                chr = base;
            end
        end else if (r_shift && sym != 8'h00) begin
            chr = sym;
        end else begin
            chr = base;
        end
        chr_valid = 1'b1;
        chr_op    = OP_INS;
        if (chr == CH_LF || chr == CH_CR) begin
            chr_op = OP_ENTER;
        end else if (chr == CH_BS) begin
            chr_op = OP_BS;
        end else if (chr == CH_TAB || (chr >= CH_SPACE && chr < CH_DEL)) begin
            chr_op = OP_INS;
        end else begin
            chr_valid = 1'b0;
        end
    end

    always_comb begin
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_caps   = r_caps;
        n_prefix = r_prefix;
        o_push   = 1'b0;
        o_cmd    = '{op: OP_INS, ch: chr};
        if (accept && !i_from_aux) begin
            priority if (i_scan_code == KEY_PREFIX) begin
                n_prefix = 1'b1;
            end else if (r_prefix) begin
                n_prefix = 1'b0;
                if ((i_scan_code & KEY_RELEASE) == 8'h00) begin
                    o_push   = nav_valid;
                    o_cmd.op = nav_op;
                end
            end else if ((i_scan_code & KEY_RELEASE) != 8'h00) begin
                if ((i_scan_code & ~KEY_RELEASE) == KEY_LSHIFT ||
                    (i_scan_code & ~KEY_RELEASE) == KEY_RSHIFT) begin
                    n_shift = 1'b0;
                end else if ((i_scan_code & ~KEY_RELEASE) == KEY_CTRL) begin
                    n_ctrl = 1'b0;
                end
            end else if (i_scan_code == KEY_LSHIFT || i_scan_code == KEY_RSHIFT) begin
                n_shift = 1'b1;
            end else if (i_scan_code == KEY_CTRL) begin
                n_ctrl = 1'b1;
            end else if (i_scan_code == KEY_CAPS) begin
                n_caps = !r_caps;
            end else if (i_scan_code >= CODE_LIMIT) begin
                o_push   = nav_valid;
                o_cmd.op = nav_op;
            end else begin
                o_push   = chr_valid;
                o_cmd.op = chr_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_caps   <= 1'b0;
            r_prefix <= 1'b0;
        end else begin
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_caps   <= n_caps;
            r_prefix <= n_prefix;
        end
    end

endmodule

`default_nettype wire

[rtl/core/kbd_cmd_fifo.sv]
// Short command queue between the decode front end and the line editor back end.
`default_nettype none

module kbd_cmd_fifo import kbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/kbd_back.sv]
// Back end: executes edit commands on the line store and streams committed lines.
`default_nettype none

module kbd_back import kbd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    input  wire t_cmd  i_cmd,
    output logic       o_cmd_pop,
    output logic       o_m_axis_tvalid,
    input  wire logic  i_m_axis_tready,
    output t_byte      o_m_axis_tdata,
    output logic       o_m_axis_tlast
);

    t_state r_state, n_state;
    t_len   r_len, n_len;
    t_len   r_cur, n_cur;
    t_len   r_ra, n_ra;
    t_byte  r_ch, n_ch;
    logic   r_ovalid;
    t_byte  r_odata;
    logic   r_olast;

    logic   out_free;
    logic   ram_we;
    t_addr  ram_waddr;
    t_byte  ram_wdata;
    t_byte  ram_rdata;
    logic   load;
    t_byte  ld_data;
    logic   ld_last;

    assign out_free = !r_ovalid || i_m_axis_tready;

    kbd_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAP)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_ra[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_INS: begin
                            if (r_len < LEN_CAP && r_cur != r_len) n_state = S_INS;
                        end
                        OP_BS: begin
                            if (r_cur != '0 && r_cur < r_len) n_state = S_REM;
                        end
                        OP_DEL: begin
                            if (r_cur + LEN_ONE < r_len) n_state = S_REM;
                        end
                        OP_ENTER: begin
                            n_state = (r_len == '0) ? S_NL : S_OUT;
                        end
                        OP_LEFT, OP_RIGHT, OP_HOME, OP_END: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_ra <= r_cur) n_state = S_INS_FIN;
            end
            S_INS_FIN: begin
                n_state = S_IDLE;
            end
            S_REM: begin
                if (r_ra + LEN_ONE >= r_len) n_state = S_IDLE;
            end
            S_OUT: begin
                if (out_free && r_ra + LEN_ONE >= r_len) n_state = S_NL;
            end
            S_NL: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_len     = r_len;
        n_cur     = r_cur;
        n_ra      = r_ra;
        n_ch      = r_ch;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_ch;
        load      = 1'b0;
        ld_data   = ram_rdata;
        ld_last   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_INS: begin
                            if (r_len < LEN_CAP) begin
                                n_ch = i_cmd.ch;
                                if (r_cur == r_len) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_cur[ADDR_W-1:0];
                                    ram_wdata = i_cmd.ch;
                                    n_len     = r_len + LEN_ONE;
                                    n_cur     = r_cur + LEN_ONE;
                                end else begin
                                    n_ra = r_len - LEN_ONE;
                                end
                            end
                        end
                        OP_BS: begin
                            if (r_cur != '0) begin
                                n_cur = r_cur - LEN_ONE;
                                if (r_cur < r_len) begin
                                    n_ra = r_cur;
                                end else begin
                                    n_len = r_len - LEN_ONE;
                                end
                            end
                        end
                        OP_DEL: begin
                            if (r_cur < r_len) begin
                                if (r_cur + LEN_ONE < r_len) begin
                                    n_ra = r_cur + LEN_ONE;
                                end else begin
                                    n_len = r_len - LEN_ONE;
                                end
                            end
                        end
                        OP_LEFT: begin
                            if (r_cur != '0) n_cur = r_cur - LEN_ONE;
                        end
                        OP_RIGHT: begin
                            if (r_cur < r_len) n_cur = r_cur + LEN_ONE;
                        end
                        OP_HOME: begin
                            n_cur = '0;
                        end
                        OP_END: begin
                            n_cur = r_len;
                        end
                        OP_ENTER: begin
                            n_ra = '0;
                        end
                    endcase
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(r_ra + LEN_ONE);
                ram_wdata = ram_rdata;
                if (r_ra > r_cur) n_ra = r_ra - LEN_ONE;
            end
            S_INS_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur[ADDR_W-1:0];
                ram_wdata = r_ch;
                n_len     = r_len + LEN_ONE;
                n_cur     = r_cur + LEN_ONE;
            end
            S_REM: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(r_ra - LEN_ONE);
                ram_wdata = ram_rdata;
                if (r_ra + LEN_ONE < r_len) begin
                    n_ra = r_ra + LEN_ONE;
                end else begin
                    n_len = r_len - LEN_ONE;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    load = 1'b1;
                    if (r_ra + LEN_ONE < r_len) n_ra = r_ra + LEN_ONE;
                end
            end
            S_NL: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_data = CH_LF;
                    ld_last = 1'b1;
                    n_len   = '0;
                    n_cur   = '0;
                end
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_cur    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cur   <= n_cur;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra <= n_ra;
        r_ch <= n_ch;
        if (load) begin
            r_odata <= ld_data;
            r_olast <= ld_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_len)
        else $error("cursor beyond end of line");
    a_length_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_CAP)
        else $error("line length over capacity");
    a_last_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata == CH_LF))
        else $error("last beat is not a newline");
    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_ra < r_len))
        else $error("commit read past end of line");
    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NL && out_free) |=> (r_len == '0 && r_cur == '0))
        else $error("line not cleared after commit");
`endif

endmodule

`default_nettype wire

[tb/tb_ps2_keyboard_line_editor.sv]
// Testbench for the keyboard line editor: keystroke streams in, committed lines checked beat by beat.
module tb_ps2_keyboard_line_editor;
    import kbd_pkg::*;

    localparam t_byte NAV_UP       = 8'h48;
    localparam t_byte NAV_DOWN     = 8'h50;
    localparam t_byte KEY_ENTER    = 8'h1C;
    localparam t_byte KEY_BKSP     = 8'h0E;
    localparam int    DIRECTED     = 24;
    localparam int    RANDOM_KEYS  = 336;
    localparam int    IDLE_LIMIT   = 4000;
    localparam int    DRAIN_CYCLES = 200;
    localparam int    MAX_REPORTS  = 10;

    typedef struct packed {
        t_byte code;
        logic  aux;
    } t_key;

    typedef struct packed {
        t_byte ch;
        logic  last;
    } t_line_char;

    t_byte base_lut [64] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    t_byte upper_lut [64] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    t_byte nav_keys [7] = '{NAV_LEFT, NAV_RIGHT, NAV_HOME, NAV_END, NAV_DEL, NAV_UP, NAV_DOWN};

    logic       i_clk;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    t_byte      s_data  = '0;
    logic       s_aux   = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_last;

    logic       shift_dn   = 1'b0;
    logic       ctrl_dn    = 1'b0;
    logic       caps_on    = 1'b0;
    logic       e0_pending = 1'b0;
    t_byte      line_buf [LINE_CAP];
    int         line_len   = 0;
    int         cur_pos    = 0;

    t_line_char line_chars_due [$];
    t_key       keys_q [$];
    int         key_count   = 0;
    int         mismatches  = 0;
    int         idle_cycles = 0;
    int         gap_left    = 0;
    int         burst_left  = 1;
    int         rx_tick     = 0;

    ps2_keyboard_line_editor dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_aux),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic drop_char(input int pos);
        for (int i = pos; i + 1 < line_len; i++) line_buf[i] = line_buf[i + 1];
        line_len--;
    endtask

    task automatic move_cursor(input t_byte code);
        case (code)
            NAV_LEFT:  if (cur_pos > 0) cur_pos--;
            NAV_RIGHT: if (cur_pos < line_len) cur_pos++;
            NAV_HOME:  cur_pos = 0;
            NAV_END:   cur_pos = line_len;
            NAV_DEL:   if (cur_pos < line_len) drop_char(cur_pos);
            default: ;
        endcase
    endtask

    task automatic predict_line(input t_byte code, input logic aux);
        t_byte mk;
        t_byte base;
        t_byte ch;
        mk = code & ~KEY_RELEASE;
        if (aux) begin
        end else if (code == KEY_PREFIX) begin
            e0_pending = 1'b1;
        end else if (e0_pending) begin
            e0_pending = 1'b0;
            if (!code[7]) move_cursor(code);
        end else if (code[7]) begin
            if (mk == KEY_LSHIFT || mk == KEY_RSHIFT) shift_dn = 1'b0;
            else if (mk == KEY_CTRL) ctrl_dn = 1'b0;
        end else if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
            shift_dn = 1'b1;
        end else if (code == KEY_CTRL) begin
            ctrl_dn = 1'b1;
        end else if (code == KEY_CAPS) begin
            caps_on = !caps_on;
        end else if (code >= CODE_LIMIT) begin
            move_cursor(code);
        end else begin
            base = base_lut[code[5:0]];
            if (base >= CH_LC_A && base <= CH_LC_Z) begin
                if (ctrl_dn) ch = base & CTRL_MASK;
                else ch = (shift_dn != caps_on) ? base - CASE_BIT : base;
            end else if (shift_dn && upper_lut[code[5:0]] != 8'h00) begin
                ch = upper_lut[code[5:0]];
            end else begin
                ch = base;
            end
            if (ch == CH_LF || ch == CH_CR) begin
                for (int i = 0; i < line_len; i++)
                    line_chars_due.push_back(t_line_char'{line_buf[i], 1'b0});
                line_chars_due.push_back(t_line_char'{CH_LF, 1'b1});
                line_len = 0;
                cur_pos  = 0;
            end else if (ch == CH_BS) begin
                if (cur_pos > 0) begin
                    drop_char(cur_pos - 1);
                    cur_pos--;
                end
            end else if ((ch == CH_TAB || (ch >= CH_SPACE && ch < CH_DEL))
                         && line_len < LINE_CAP) begin
                for (int i = line_len; i > cur_pos; i--) line_buf[i] = line_buf[i - 1];
                line_buf[cur_pos] = ch;
                line_len++;
                cur_pos++;
            end
        end
    endtask

    task automatic push_key(input t_byte code, input logic aux = 1'b0);
        keys_q.push_back(t_key'{code, aux});
        if (!aux) key_count++;
    endtask

    task automatic tap(input t_byte code);
        push_key(code);
        if ($urandom_range(0, 2) == 0) push_key(code | KEY_RELEASE);
    endtask

    function automatic t_byte pick_char(input logic letter);
        t_byte code;
        t_byte v;
        logic  ok;
        ok   = 1'b0;
        code = '0;
        while (!ok) begin
            code = t_byte'($urandom_range(2, 57));
            v    = base_lut[code[5:0]];
            ok   = letter ? (v >= CH_LC_A && v <= CH_LC_Z) : (v >= CH_SPACE && v < CH_DEL);
        end
        return code;
    endfunction

    always @(posedge i_clk) begin : drive_keys
        t_key nxt;
        logic free;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            free = !s_valid;
            if (s_valid && s_ready) begin
                predict_line(s_data, s_aux);
                free = 1'b1;
            end
            if (free) begin
                if (gap_left > 0 || keys_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    nxt = keys_q.pop_front();
                    s_data  <= nxt.code;
                    s_aux   <= nxt.aux;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                                  : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : pace_sink
        rx_tick++;
        case (rx_tick[10:9])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= $urandom_range(0, 1);
            2'd2: m_ready <= (rx_tick % 5 == 0);
            default: m_ready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge i_clk) begin : check_lines
        t_line_char want;
        if (rst_n && m_valid && m_ready) begin
            if (line_chars_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: char %h last %b", m_data, m_last);
            end else begin
                want = line_chars_due.pop_front();
                if (m_data !== want.ch || m_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("line beat mismatch: char exp %h got %h, last exp %b got %b",
                                 want.ch, m_data, want.last, m_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : run
        int    sel;
        t_byte code;

        push_key(8'h1E, 1'b1);
        push_key(8'h00);
        push_key(8'hFF);
        push_key(KEY_ENTER);
        push_key(KEY_LSHIFT);
        push_key(8'h02);
        push_key(KEY_LSHIFT | KEY_RELEASE);
        push_key(KEY_CAPS);
        push_key(8'h30);
        push_key(KEY_RSHIFT);
        push_key(8'h30);
        push_key(KEY_RSHIFT | KEY_RELEASE);
        push_key(KEY_PREFIX);
        push_key(KEY_PREFIX);
        push_key(NAV_LEFT);
        push_key(KEY_BKSP);
        push_key(NAV_HOME);
        push_key(KEY_BKSP);
        push_key(KEY_PREFIX);
        push_key(NAV_END | KEY_RELEASE);
        push_key(KEY_CTRL);
        push_key(8'h17);
        push_key(8'h23);
        push_key(8'h32);
        push_key(KEY_CTRL | KEY_RELEASE);

        // overfill the line, the second batch of keys inserted at the front
        repeat (30) push_key(pick_char(1'b0));
        push_key(NAV_HOME);
        repeat (36) push_key(pick_char(1'b0));
        push_key(NAV_END);
        push_key(NAV_DEL);
        push_key(NAV_RIGHT);
        push_key(KEY_ENTER);

        while (key_count < DIRECTED + RANDOM_KEYS) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                repeat ($urandom_range(1, 8)) tap(pick_char(1'b0));
            end else if (sel < 40) begin
                push_key($urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT);
                repeat ($urandom_range(1, 4)) tap(pick_char(1'b0));
                push_key(($urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT) | KEY_RELEASE);
            end else if (sel < 45) begin
                tap(KEY_CAPS);
            end else if (sel < 52) begin
                push_key(KEY_CTRL);
                tap(pick_char(1'b1));
                push_key(KEY_CTRL | KEY_RELEASE);
            end else if (sel < 66) begin
                code = nav_keys[$urandom_range(0, 6)];
                if ($urandom_range(0, 1)) begin
                    push_key(KEY_PREFIX);
                    push_key(code);
                    if ($urandom_range(0, 1)) begin
                        push_key(KEY_PREFIX);
                        push_key(code | KEY_RELEASE);
                    end
                end else begin
                    tap(code);
                end
            end else if (sel < 74) begin
                tap(KEY_BKSP);
            end else if (sel < 86) begin
                tap(KEY_ENTER);
            end else if (sel < 95) begin
                push_key(t_byte'($urandom_range(0, 255)));
            end else begin
                push_key(t_byte'($urandom_range(0, 255)), 1'b1);
            end
        end

        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        while (keys_q.size() != 0 || s_valid) @(posedge i_clk);
        while (line_chars_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && line_chars_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/kbd_pkg.sv
rtl/core/kbd_ram.sv
rtl/core/kbd_front.sv
rtl/core/kbd_cmd_fifo.sv
rtl/core/kbd_back.sv
rtl/core/ps2_keyboard_line_editor.sv
tb/tb_ps2_keyboard_line_editor.sv
